### rtl/rgbihls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbihls_pkg
// Shared types and fixed-point constants of the RGB to IHLS converter.
// ----------------------------------------------------------------------------
package rgbihls_pkg;

	localparam int XY_W = 29;   // signed Q16 vector components
	localparam int Z_W  = 20;   // signed Q16 angle accumulator
	localparam int A_W  = 19;   // unsigned Q16 final angle
	localparam int CORDIC_STEPS = 17;

	localparam logic [16:0] SQRT3_Q16     = 17'd113512;
	localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic signed [Z_W-1:0] PI_Q16      = 20'sd205887;
	localparam logic [A_W-1:0] TWO_PI_Q16  = 19'd411775;
	localparam logic [A_W-1:0] ANGLE_MAX   = 19'd411774;
	localparam logic [21:0] HUE_SCALE_Q16 = 22'd2659746;
	localparam logic [13:0] LUMA_R_Q16 = 14'd13763;
	localparam logic [15:0] LUMA_G_Q16 = 16'd46858;
	localparam logic [12:0] LUMA_B_Q16 = 13'd4719;

	// Side information that travels with the vector through the steps.
	typedef struct packed {
		logic       gray;
		logic       b_gt_g;
		logic [7:0] sat;
		logic [7:0] luma;
	} side_t;

	// atan(2^-i) in Q16, rounded.
	function automatic logic signed [Z_W-1:0] atan_q16(input int i);
		logic signed [Z_W-1:0] v;
		unique case (i)
			0: v = 20'sd51472;
			1: v = 20'sd30386;
			2: v = 20'sd16055;
			3: v = 20'sd8150;
			4: v = 20'sd4091;
			5: v = 20'sd2047;
			6: v = 20'sd1024;
			7: v = 20'sd512;
			8: v = 20'sd256;
			9: v = 20'sd128;
			10: v = 20'sd64;
			11: v = 20'sd32;
			12: v = 20'sd16;
			13: v = 20'sd8;
			14: v = 20'sd4;
			15: v = 20'sd2;
			default: v = 20'sd1;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### rtl/rgbihls_cordic_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbihls_cordic_stage
// One registered vectoring step of the hue CORDIC.
// ----------------------------------------------------------------------------
module rgbihls_cordic_stage #(
	parameter int SHIFT = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_in,
	input  wire logic signed [rgbihls_pkg::XY_W-1:0] x_in,
	input  wire logic signed [rgbihls_pkg::XY_W-1:0] y_in,
	input  wire logic signed [rgbihls_pkg::Z_W-1:0]  z_in,
	input  wire rgbihls_pkg::side_t side_in,
	output logic valid_out,
	output logic signed [rgbihls_pkg::XY_W-1:0] x_out,
	output logic signed [rgbihls_pkg::XY_W-1:0] y_out,
	output logic signed [rgbihls_pkg::Z_W-1:0]  z_out,
	output rgbihls_pkg::side_t side_out
);
	import rgbihls_pkg::*;

	localparam logic signed [Z_W-1:0] ATAN = atan_q16(SHIFT);

	logic signed [XY_W-1:0] xs, ys;
	assign xs = x_in >>> SHIFT;
	assign ys = y_in >>> SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_out <= side_in;
			if (!y_in[XY_W-1]) begin
				x_out <= x_in + ys;
				y_out <= y_in - xs;
				z_out <= z_in + ATAN;
			end else begin
				x_out <= x_in - ys;
				y_out <= y_in + xs;
				z_out <= z_in - ATAN;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/rgb_to_ihls_pixel_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_ihls_pixel_top
// RGB pixel to IHLS saturation, luminance and hue, fully pipelined.
// ----------------------------------------------------------------------------
// From an accepted request to its result the pipe holds two setup stages,
// seventeen CORDIC steps, one clamp stage and one hue scaling stage.
// Throughput is one pixel per cycle while the output is not stalled; each
// CORDIC step owns a register stage. A stall at the output freezes the pipe.
// Reset clears all valid bits asynchronously; the pipe is empty afterwards.
module rgb_to_ihls_pixel_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      saturation_out,
	output logic [7:0]      luminance_out,
	output logic [7:0]      hue_out
);
	import rgbihls_pkg::*;

	// The pipe moves as one unit whenever the result register is free or
	// being taken. Bubbles move along with it.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Stage 1: channel spread, starting vector and luminance products.
	logic [7:0] mx, mn;
	logic signed [10:0] dx;
	logic [7:0] dgb;
	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		dx = $signed({2'b00, red, 1'b0}) - $signed({3'b000, green})
			- $signed({3'b000, blue});
		dgb = (green > blue) ? (green - blue) : (blue - green);
	end

	// The green-blue spread times sqrt(3) needs the full 25 bits.
	logic [24:0] y0_prod;
	assign y0_prod = dgb * SQRT3_Q16;

	logic valid_s1, gray_s1, bgtg_s1;
	logic [7:0] sat_s1;
	logic signed [XY_W-1:0] x_s1, y_s1;
	logic [21:0] pr_s1;
	logic [23:0] pg_s1;
	logic [20:0] pb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gray_s1 <= (red == green) && (green == blue);
			bgtg_s1 <= blue > green;
			sat_s1  <= mx - mn;
			x_s1    <= {{(XY_W-27){dx[10]}}, dx, 16'h0000};
			y_s1    <= $signed({{(XY_W-25){1'b0}}, y0_prod});
			pr_s1   <= red * LUMA_R_Q16;
			pg_s1   <= green * LUMA_G_Q16;
			pb_s1   <= blue * LUMA_B_Q16;
		end
	end

	// Stage 2: turn left half-plane vectors by a quarter turn, finish luma.
	logic [23:0] luma_sum;
	assign luma_sum = {2'b00, pr_s1} + pg_s1 + {3'b000, pb_s1};

	logic valid_s2;
	logic signed [XY_W-1:0] x_s2, y_s2;
	logic signed [Z_W-1:0]  z_s2;
	side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.gray   <= gray_s1;
			side_s2.b_gt_g <= bgtg_s1;
			side_s2.sat    <= sat_s1;
			side_s2.luma   <= luma_sum[23:16];
			if (x_s1[XY_W-1]) begin
				x_s2 <= y_s1;
				y_s2 <= -x_s1;
				z_s2 <= HALF_PI_Q16;
			end else begin
				x_s2 <= x_s1;
				y_s2 <= y_s1;
				z_s2 <= '0;
			end
		end
	end

	// Seventeen vectoring steps, one per stage.
	logic                   cv [0:CORDIC_STEPS];
	logic signed [XY_W-1:0] cx [0:CORDIC_STEPS];
	logic signed [XY_W-1:0] cy [0:CORDIC_STEPS];
	logic signed [Z_W-1:0]  cz [0:CORDIC_STEPS];
	side_t                  cs [0:CORDIC_STEPS];

	assign cv[0] = valid_s2;
	assign cx[0] = x_s2;
	assign cy[0] = y_s2;
	assign cz[0] = z_s2;
	assign cs[0] = side_s2;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		rgbihls_cordic_stage #(.SHIFT(i)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (cv[i]),
			.x_in     (cx[i]),
			.y_in     (cy[i]),
			.z_in     (cz[i]),
			.side_in  (cs[i]),
			.valid_out(cv[i+1]),
			.x_out    (cx[i+1]),
			.y_out    (cy[i+1]),
			.z_out    (cz[i+1]),
			.side_out (cs[i+1])
		);
	end

	// Stage 20: clamp theta to [0, pi], mirror it when blue exceeds green,
	// and force gray pixels to zero.
	logic signed [Z_W-1:0] zf;
	logic [A_W-1:0] theta, angle;
	assign zf = cz[CORDIC_STEPS];
	always_comb begin
		if (zf[Z_W-1]) begin
			theta = '0;
		end else if (zf > PI_Q16) begin
			theta = PI_Q16[A_W-1:0];
		end else begin
			theta = zf[A_W-1:0];
		end
		if (cs[CORDIC_STEPS].gray) begin
			angle = '0;
		end else if (cs[CORDIC_STEPS].b_gt_g) begin
			angle = (theta == '0) ? ANGLE_MAX : (TWO_PI_Q16 - theta);
		end else begin
			angle = theta;
		end
	end

	logic valid_s20;
	logic [A_W-1:0] angle_s20;
	side_t side_s20;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s20 <= 1'b0;
		end else if (en) begin
			valid_s20 <= cv[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s20 <= angle;
			side_s20  <= cs[CORDIC_STEPS];
		end
	end

	// Stage 21: scale the angle so a full turn maps to 255.
	logic [40:0] hue_prod;
	assign hue_prod = angle_s20 * HUE_SCALE_Q16;

	logic valid_s21;
	logic [7:0] sat_s21, luma_s21, hue_s21;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s21 <= 1'b0;
		end else if (en) begin
			valid_s21 <= valid_s20;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s21  <= side_s20.sat;
			luma_s21 <= side_s20.luma;
			hue_s21  <= hue_prod[40] ? 8'hff : hue_prod[39:32];
		end
	end

	assign out_valid      = valid_s21;
	assign saturation_out = sat_s21;
	assign luminance_out  = luma_s21;
	assign hue_out        = hue_s21;

endmodule
`default_nettype wire

### rtl/rgbihls_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbihls_checker
// Port-level assertions for the RGB to IHLS converter, bound to the top.
// ----------------------------------------------------------------------------
module rgbihls_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] red,
	input wire logic [7:0] green,
	input wire logic [7:0] blue,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] saturation_out,
	input wire logic [7:0] luminance_out,
	input wire logic [7:0] hue_out
);

	// The input is held back exactly when a finished result is blocked.
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output back-pressure");

	// A stalled request stays and does not change.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(red)
			&& $stable(green) && $stable(blue))
		else $error("stalled request changed");

	// A blocked result stays and does not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(saturation_out)
			&& $stable(luminance_out) && $stable(hue_out))
		else $error("blocked result changed");

	// The angle clamp keeps the hue below a full turn.
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hue_out != 8'hff)
		else $error("hue reached a full turn");

	// Luminance weights sum below one, so it never saturates.
	a_luma_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> luminance_out != 8'hff)
		else $error("luminance out of range");

endmodule

bind rgb_to_ihls_pixel_top rgbihls_checker u_rgbihls_checker (.*);
`default_nettype wire
